FILE: rtl/core/gte_pkg.sv
// Shared constants, types and state codes for the glare threshold estimate core.
`default_nettype none

package gte_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W = $clog2(MAX_PIXELS);
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int VAL_W = 24;
	localparam int THR_W = VAL_W - 1;
	localparam int RATIO_W = 4;
	localparam int RBIT_W = $clog2(RATIO_W);
	localparam int SUM_W = VAL_W + ADDR_W;
	localparam int PROD_W = VAL_W + CNT_W + 1;
	localparam int LIM_W = SUM_W + RATIO_W + 1;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_CHECK,
		ST_CHKWAIT,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} gte_state_t;

	// Request into the shared cutoff unit: one value to test against the cutoff.
	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] val;
	} cut_req_t;

	// Answer from the cutoff unit; the request passes the product register and the compare register first.
	typedef struct packed {
		logic                    vld;
		logic                    busy;
		logic                    in_limit;
		logic signed [VAL_W-1:0] val;
	} cut_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/gte_ifs.sv
// Handshake channel interfaces for pixel input, result output and configuration.
`default_nettype none

interface gte_pix_if;
	logic                              valid;
	logic                              ready;
	logic signed [gte_pkg::VAL_W-1:0] red_value;
	logic signed [gte_pkg::VAL_W-1:0] green_value;
	logic signed [gte_pkg::VAL_W-1:0] blue_value;
	logic                              last_pixel;

	modport source (output valid, red_value, green_value, blue_value, last_pixel,
		input ready);
	modport sink (input valid, red_value, green_value, blue_value, last_pixel,
		output ready);
endinterface

interface gte_res_if;
	logic                       valid;
	logic                       ready;
	logic [gte_pkg::THR_W-1:0] threshold;
	logic                       glare_clipped;

	modport source (output valid, threshold, glare_clipped, input ready);
	modport sink (input valid, threshold, glare_clipped, output ready);
endinterface

interface gte_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [gte_pkg::RATIO_W-1:0] glare_ratio;

	modport source (output valid, glare_ratio, input ready);
	modport sink (input valid, glare_ratio, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gte_store.sv
// Single-port-write, registered-read memory holding the per-pixel maxima.
`default_nettype none

module gte_store (
	input  wire logic                              clk,
	input  wire logic                              wr_en,
	input  wire logic [gte_pkg::ADDR_W-1:0]        wr_addr,
	input  wire logic signed [gte_pkg::VAL_W-1:0]  wr_data,
	input  wire logic                              rd_en,
	input  wire logic [gte_pkg::ADDR_W-1:0]        rd_addr,
	output logic signed [gte_pkg::VAL_W-1:0]       rd_data
);

	logic signed [gte_pkg::VAL_W-1:0] mem [gte_pkg::MAX_PIXELS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/gte_cut_unit.sv
// Shared cutoff test unit: registered value*count product, then compare with the limit.
`default_nettype none

module gte_cut_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire gte_pkg::cut_req_t                 req,
	input  wire logic [gte_pkg::CNT_W-1:0]         count,
	input  wire logic signed [gte_pkg::LIM_W-1:0]  limit,
	output gte_pkg::cut_rsp_t                      rsp
);

	logic signed [gte_pkg::CNT_W:0]   cnt_s;
	logic signed [gte_pkg::PROD_W-1:0] prod_d;
	logic signed [gte_pkg::PROD_W-1:0] prod_s1;
	logic signed [gte_pkg::LIM_W-1:0]  prod_ext;
	logic signed [gte_pkg::VAL_W-1:0]  val_s1;
	logic signed [gte_pkg::VAL_W-1:0]  val_s2;
	logic                              vld_s1;
	logic                              vld_s2;
	logic                              within_s2;

	assign cnt_s = {1'b0, count};
	assign prod_d = $signed(req.val) * cnt_s;
	assign prod_ext = {{(gte_pkg::LIM_W - gte_pkg::PROD_W){prod_s1[gte_pkg::PROD_W-1]}},
		prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		val_s1 <= req.val;
		within_s2 <= (prod_ext <= limit);
		val_s2 <= val_s1;
	end

	always_comb begin
		rsp.vld = vld_s2;
		rsp.busy = vld_s1 | vld_s2;
		rsp.in_limit = within_s2;
		rsp.val = val_s2;
	end

endmodule

`default_nettype wire

FILE: rtl/core/glare_threshold_estimate_core.sv
// Top level: pixel loading, cutoff sequencer, second pass and result register.
//
//   channel | dir | handshake     | word
//   pix     | in  | valid/ready   | red_value, green_value, blue_value, last_pixel
//   res     | out | valid/ready   | threshold, glare_clipped
//   cfg     | in  | valid/ready   | glare_ratio (ready always high)
//
// An ordinary pixel is stored, summed and counted as it is accepted, while the store has room.
// The last pixel is followed by the shift-add limit, the maximum check and the emit step;
// when the maximum fails the check, a sweep over the N stored pixels and a drain follow,
// N the pixel count, the sweep paced by the single read port of the pixel store.
// Reset clears the sum, maximum, count and sequencer and sets glare_ratio to 5.
// A waiting result holds only the emit step; pixels of the next image are still taken.
`default_nettype none

module glare_threshold_estimate_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gte_pix_if.sink    pix,
	gte_res_if.source  res,
	gte_cfg_if.sink    cfg
);

	gte_pkg::gte_state_t state_q;
	gte_pkg::gte_state_t state_d;

	logic [gte_pkg::RATIO_W-1:0]      ratio_q;
	logic signed [gte_pkg::SUM_W-1:0] sum_q;
	logic [gte_pkg::THR_W-1:0]        max_q;
	logic [gte_pkg::CNT_W-1:0]        cnt_q;
	logic [gte_pkg::CNT_W-1:0]        idx_q;
	logic signed [gte_pkg::LIM_W-1:0] lim_q;
	logic [gte_pkg::RBIT_W-1:0]       bit_q;
	logic [gte_pkg::THR_W-1:0]        best_q;
	logic                             clip_q;
	logic                             rd_vld_s1;
	logic                             out_vld_q;
	logic [gte_pkg::THR_W-1:0]        out_thr_q;
	logic                             out_clip_q;

	logic signed [gte_pkg::VAL_W-1:0] pix_m;
	logic signed [gte_pkg::VAL_W-1:0] rg_m;
	logic signed [gte_pkg::VAL_W-1:0] max_ext;
	logic signed [gte_pkg::VAL_W-1:0] best_ext;
	logic signed [gte_pkg::LIM_W-1:0] sum_ext;
	logic signed [gte_pkg::VAL_W-1:0] rd_data;
	logic                             pix_acc;
	logic                             has_room;
	logic                             rd_en;
	logic                             emit_go;
	logic                             sweep_end;
	logic                             limit_end;
	gte_pkg::cut_req_t                cut_req;
	gte_pkg::cut_rsp_t                cut_rsp;

	assign rg_m = (pix.green_value > pix.red_value) ? pix.green_value : pix.red_value;
	assign pix_m = (pix.blue_value > rg_m) ? pix.blue_value : rg_m;
	assign pix_acc = pix.valid & pix.ready;
	assign has_room = cnt_q < gte_pkg::CNT_W'(gte_pkg::MAX_PIXELS);
	assign max_ext = {1'b0, max_q};
	assign best_ext = {1'b0, best_q};
	assign sum_ext = {{(gte_pkg::LIM_W - gte_pkg::SUM_W){sum_q[gte_pkg::SUM_W-1]}}, sum_q};
	assign sweep_end = (idx_q + gte_pkg::CNT_W'(1)) == cnt_q;
	assign limit_end = bit_q == gte_pkg::RBIT_W'(gte_pkg::RATIO_W - 1);

	assign cfg.ready = 1'b1;
	assign res.valid = out_vld_q;
	assign res.threshold = out_thr_q;
	assign res.glare_clipped = out_clip_q;

	gte_store u_store (
		.clk     (clk),
		.wr_en   (pix_acc & has_room),
		.wr_addr (cnt_q[gte_pkg::ADDR_W-1:0]),
		.wr_data (pix_m),
		.rd_en   (rd_en),
		.rd_addr (idx_q[gte_pkg::ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		cut_req.vld = (state_q == gte_pkg::ST_CHECK) | rd_vld_s1;
		cut_req.val = (state_q == gte_pkg::ST_CHECK) ? max_ext : rd_data;
	end

	gte_cut_unit u_cut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cut_req),
		.count  (cnt_q),
		.limit  (lim_q),
		.rsp    (cut_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gte_pkg::ST_IDLE: begin
				if (pix_acc && pix.last_pixel) begin
					state_d = gte_pkg::ST_LIMIT;
				end
			end
			gte_pkg::ST_LIMIT: begin
				if (limit_end) begin
					state_d = gte_pkg::ST_CHECK;
				end
			end
			gte_pkg::ST_CHECK: begin
				state_d = gte_pkg::ST_CHKWAIT;
			end
			gte_pkg::ST_CHKWAIT: begin
				if (cut_rsp.vld) begin
					state_d = cut_rsp.in_limit ? gte_pkg::ST_EMIT : gte_pkg::ST_SWEEP;
				end
			end
			gte_pkg::ST_SWEEP: begin
				if (sweep_end) begin
					state_d = gte_pkg::ST_DRAIN;
				end
			end
			gte_pkg::ST_DRAIN: begin
				if (!rd_vld_s1 && !cut_rsp.busy) begin
					state_d = gte_pkg::ST_EMIT;
				end
			end
			gte_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = gte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gte_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		pix.ready = 1'b0;
		rd_en = 1'b0;
		emit_go = 1'b0;
		case (state_q)
			gte_pkg::ST_IDLE: begin
				pix.ready = 1'b1;
			end
			gte_pkg::ST_SWEEP: begin
				rd_en = 1'b1;
			end
			gte_pkg::ST_EMIT: begin
				emit_go = !out_vld_q || res.ready;
			end
			default: begin
				pix.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gte_pkg::ST_IDLE;
			ratio_q <= gte_pkg::RATIO_RESET;
			sum_q <= '0;
			max_q <= '0;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg.valid && cfg.ready) begin
				ratio_q <= cfg.glare_ratio;
			end
			if (pix_acc && has_room) begin
				sum_q <= sum_q + {{(gte_pkg::SUM_W - gte_pkg::VAL_W){pix_m[gte_pkg::VAL_W-1]}},
					pix_m};
				cnt_q <= cnt_q + gte_pkg::CNT_W'(1);
				if (pix_m > max_ext) begin
					max_q <= pix_m[gte_pkg::THR_W-1:0];
				end
			end
			if (emit_go) begin
				sum_q <= '0;
				max_q <= '0;
				cnt_q <= '0;
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gte_pkg::ST_IDLE) begin
			lim_q <= '0;
			bit_q <= '0;
		end else if (state_q == gte_pkg::ST_LIMIT) begin
			// Shift-add of the sum, one ratio bit per cycle.
			if (ratio_q[bit_q]) begin
				lim_q <= lim_q + (sum_ext <<< bit_q);
			end
			bit_q <= bit_q + gte_pkg::RBIT_W'(1);
		end
		if (state_q == gte_pkg::ST_CHKWAIT && cut_rsp.vld) begin
			idx_q <= '0;
			if (cut_rsp.in_limit) begin
				best_q <= max_q;
				clip_q <= 1'b0;
			end else begin
				best_q <= '0;
				clip_q <= 1'b1;
			end
		end else begin
			if (state_q == gte_pkg::ST_SWEEP) begin
				idx_q <= idx_q + gte_pkg::CNT_W'(1);
			end
			if (cut_rsp.vld && cut_rsp.in_limit && (cut_rsp.val > best_ext)) begin
				best_q <= cut_rsp.val[gte_pkg::THR_W-1:0];
			end
		end
		if (emit_go) begin
			out_thr_q <= best_q;
			out_clip_q <= clip_q;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gte_pkg::CNT_W'(gte_pkg::MAX_PIXELS))
		else $error("pixel count beyond store depth");

	a_sweep_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gte_pkg::ST_SWEEP) |-> (idx_q < cnt_q))
		else $error("sweep reads past the pixels of this image");

	a_best_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gte_pkg::ST_DRAIN || state_q == gte_pkg::ST_EMIT) |-> (best_q <= max_q))
		else $error("second pass found a value above the running maximum");

	a_cut_rsp_state: assert property (@(posedge clk) disable iff (!arst_n)
		cut_rsp.vld |-> (state_q == gte_pkg::ST_CHKWAIT || state_q == gte_pkg::ST_SWEEP ||
		state_q == gte_pkg::ST_DRAIN))
		else $error("cutoff answer arrived outside the check or sweep");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_glare_threshold_estimate_core.sv
// Self-checking testbench for the glare threshold estimate core.
`default_nettype none

module tb_glare_threshold_estimate_core;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int CALM_ITEMS = 960;
	localparam logic signed [gte_pkg::VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
	localparam logic signed [gte_pkg::VAL_W-1:0] VAL_MIN = 24'sh800000;

	typedef enum int {
		SCENE_GLARE,
		SCENE_NOISE,
		SCENE_DARK,
		SCENE_FLAT
	} scene_t;

	typedef struct {
		logic [gte_pkg::THR_W-1:0] threshold;
		logic                      glare_clipped;
	} thr_word_t;

	logic clk = 1'b0;
	logic arst_n;

	gte_pix_if pix_ch ();
	gte_res_if res_ch ();
	gte_cfg_if cfg_ch ();

	glare_threshold_estimate_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	int unsigned cycle_cnt = 0;
	int          fail_cnt = 0;
	int          items_sent = 0;
	bit          idle_en = 1'b1;

	// Predicted image state and the thresholds still owed by the block.
	longint                      img_vals[$];
	longint                      img_sum = 0;
	longint                      img_max = 0;
	longint                      img_cnt = 0;
	logic [gte_pkg::RATIO_W-1:0] ratio_model = gte_pkg::RATIO_RESET;
	thr_word_t                   thr_expected_q[$];

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("FAIL glare_threshold_estimate_core");
		$finish;
	end

	// Fold one accepted pixel into the image; on the last pixel work out the threshold.
	task automatic absorb_pixel(input logic signed [gte_pkg::VAL_W-1:0] r, g, b,
		input logic last);
		longint    m;
		longint    limit;
		longint    best;
		thr_word_t w;
		m = r;
		if (longint'(g) > m) m = g;
		if (longint'(b) > m) m = b;
		if (img_cnt < gte_pkg::MAX_PIXELS) begin
			img_vals.push_back(m);
			img_cnt++;
			img_sum += m;
			if (m > img_max) img_max = m;
		end
		if (last) begin
			limit = longint'(ratio_model) * img_sum;
			best = img_max;
			w.glare_clipped = 1'b0;
			if (img_max * img_cnt > limit) begin
				w.glare_clipped = 1'b1;
				best = 0;
				foreach (img_vals[i]) begin
					if (img_vals[i] * img_cnt <= limit && img_vals[i] > best) best = img_vals[i];
				end
			end
			w.threshold = best[gte_pkg::THR_W-1:0];
			thr_expected_q.push_back(w);
			img_vals.delete();
			img_sum = 0;
			img_max = 0;
			img_cnt = 0;
		end
	endtask

	// Sends one pixel word, with an occasional idle burst in front of it.
	task automatic send_pixel(input logic signed [gte_pkg::VAL_W-1:0] r, g, b,
		input logic last);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			pix_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_ch.valid <= 1'b1;
		pix_ch.red_value <= r;
		pix_ch.green_value <= g;
		pix_ch.blue_value <= b;
		pix_ch.last_pixel <= last;
		do @(posedge clk); while (!pix_ch.ready);
		absorb_pixel(r, g, b, last);
		items_sent++;
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (thr_expected_q.size() != 0) @(posedge clk);
		// The last result has been accepted here, so the block is back in its idle state.
		repeat (8) @(posedge clk);
	endtask

	task automatic write_ratio(input logic [gte_pkg::RATIO_W-1:0] val);
		wait_results_done();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.glare_ratio <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		ratio_model = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Result checker: every accepted result word is matched against the oldest prediction.
	initial begin
		thr_word_t w;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (thr_expected_q.size() == 0) begin
					$error("unexpected result word: threshold %0d, glare_clipped %0d",
						res_ch.threshold, res_ch.glare_clipped);
					fail_cnt++;
				end else begin
					w = thr_expected_q.pop_front();
					if (res_ch.threshold !== w.threshold) begin
						$error("threshold: expected %0d, actual %0d", w.threshold,
							res_ch.threshold);
						fail_cnt++;
					end
					if (res_ch.glare_clipped !== w.glare_clipped) begin
						$error("glare_clipped: expected %0d, actual %0d", w.glare_clipped,
							res_ch.glare_clipped);
						fail_cnt++;
					end
				end
			end
		end
	end

	// Result-side back-pressure in random bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [gte_pkg::VAL_W-1:0] pick_component(input scene_t scene);
		int t;
		case (scene)
			SCENE_GLARE: begin
				if ($urandom_range(0, 11) == 0) t = $urandom_range(50000, 8388607);
				else t = $urandom_range(0, 3000);
			end
			SCENE_NOISE: t = $urandom();
			SCENE_DARK: begin
				if ($urandom_range(0, 5) == 0) t = $urandom_range(0, 2000);
				else t = -int'($urandom_range(0, 8388608));
			end
			default: t = 1000 + $urandom_range(0, 3);
		endcase
		return t[gte_pkg::VAL_W-1:0];
	endfunction

	task automatic test_default_ratio();
		send_pixel(24'sd97, 24'sd100, 24'sd93, 1'b0);
		send_pixel(24'sd100, 24'sd90, 24'sd80, 1'b0);
		send_pixel(24'sd60, 24'sd70, 24'sd100, 1'b0);
		send_pixel(24'sd100000, 24'sd5, 24'sd5, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_pixel(VAL_MAX, 24'sd0, VAL_MIN, 1'b1);
		send_pixel(VAL_MIN, VAL_MAX, 24'sd0, 1'b0);
		send_pixel(VAL_MIN, VAL_MIN, VAL_MIN, 1'b1);
	endtask

	task automatic test_all_negative();
		send_pixel(-24'sd5, -24'sd9, -24'sd1, 1'b0);
		send_pixel(-24'sd300, -24'sd200, -24'sd100, 1'b0);
		send_pixel(VAL_MIN, -24'sd7, VAL_MIN, 1'b1);
	endtask

	// A positive maximum over a negative sum leaves the second pass with nothing.
	task automatic test_negative_sum();
		send_pixel(24'sd100, 24'sd0, 24'sd0, 1'b0);
		send_pixel(-24'sd1000, -24'sd1000, -24'sd1000, 1'b0);
		send_pixel(24'sd0, 24'sd50, 24'sd0, 1'b1);
	endtask

	task automatic test_ratio_settings();
		write_ratio(4'd0);
		send_pixel(24'sd10, 24'sd0, 24'sd0, 1'b0);
		send_pixel(24'sd0, 24'sd20, 24'sd0, 1'b0);
		send_pixel(24'sd0, 24'sd0, 24'sd0, 1'b1);
		write_ratio(4'd15);
		repeat (4) send_pixel(24'sd1, 24'sd1, 24'sd1, 1'b0);
		send_pixel(24'sd0, 24'sd0, 24'sd1000, 1'b1);
		write_ratio(4'd1);
		send_pixel(24'sd10, 24'sd0, 24'sd0, 1'b0);
		send_pixel(24'sd20, 24'sd0, 24'sd0, 1'b0);
		send_pixel(24'sd30, 24'sd0, 24'sd0, 1'b1);
	endtask

	// Fills the pixel store and pushes more pixels that must be ignored.
	task automatic test_pixel_overflow();
		logic signed [gte_pkg::VAL_W-1:0] v;
		write_ratio(4'd5);
		idle_en = 1'b0;
		for (int i = 0; i < gte_pkg::MAX_PIXELS + 2; i++) begin
			if (i >= gte_pkg::MAX_PIXELS) v = VAL_MAX;
			else if (i % 4096 == 7) v = VAL_MAX;
			else if (i % 1000 == 3) v = gte_pkg::VAL_W'($urandom_range(5000, 20000));
			else v = gte_pkg::VAL_W'($urandom_range(0, 255));
			send_pixel(v, -24'sd1, v >>> 1, i == gte_pkg::MAX_PIXELS + 1);
		end
		idle_en = 1'b1;
		wait_results_done();
	endtask

	task automatic test_random_images();
		int     len;
		scene_t scene;
		int     pick;
		while (items_sent < RANDOM_ITEMS + 25 + gte_pkg::MAX_PIXELS + 2) begin
			idle_en = (items_sent < CALM_ITEMS + 25 + gte_pkg::MAX_PIXELS + 2);
			if ($urandom_range(0, 11) == 0) begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: write_ratio(4'd1);
					1: write_ratio(4'd15);
					2: write_ratio(4'd0);
					default: write_ratio(4'($urandom_range(1, 15)));
				endcase
			end
			pick = $urandom_range(0, 9);
			if (pick <= 5) scene = SCENE_GLARE;
			else if (pick <= 7) scene = SCENE_NOISE;
			else if (pick == 8) scene = SCENE_DARK;
			else scene = SCENE_FLAT;
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				send_pixel(pick_component(scene), pick_component(scene), pick_component(scene),
					i == len - 1);
			end
		end
		wait_results_done();
	endtask

	initial begin
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.red_value = '0;
		pix_ch.green_value = '0;
		pix_ch.blue_value = '0;
		pix_ch.last_pixel = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.glare_ratio = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_default_ratio();
		test_field_extremes();
		test_all_negative();
		test_negative_sum();
		test_ratio_settings();
		test_pixel_overflow();
		test_random_images();

		repeat (32) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("PASS glare_threshold_estimate_core");
		end else begin
			$display("FAIL glare_threshold_estimate_core");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/gte_pkg.sv
rtl/core/gte_ifs.sv
rtl/core/gte_store.sv
rtl/core/gte_cut_unit.sv
rtl/core/glare_threshold_estimate_core.sv
verif/tb_glare_threshold_estimate_core.sv
